// ----- src/small_matrix_multiply_core_assert.svh -----
// Assertion macros shared by the matrix multiply modules.
`ifndef SMALL_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define SMALL_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// Condition and consequence checked at the same clock edge.
`define SMM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence checked at the clock edge after the condition.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/smm_pkg.sv -----
// Types and constants shared by the matrix multiply modules.
package smm_pkg;

	localparam int COORD_W   = 3;
	localparam int DIM_W     = 4;
	localparam int ELEM_BITS = 16;
	localparam int FRAC_BITS = 8;
	localparam int OP_W      = 2;

	localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_MISMATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT,
		ST_ERR
	} smm_state_t;

	// effective (clamped) matrix sizes
	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_rows;
		logic [DIM_W-1:0] b_cols;
	} smm_dims_t;

	// controller -> datapath
	typedef struct packed {
		logic               wr_a;
		logic               wr_b;
		logic               rd_en;
		logic               clr_acc;
		logic               emit_elem;
		logic               emit_err;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] k;
	} smm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic slot_free;
	} smm_sts_t;

endpackage

// ----- src/smm_ctrl.sv -----
// Sequencer: walks rows, columns and the inner sum of the product.
module smm_ctrl
	import smm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0] op,
	input  smm_dims_t       dims,
	input  smm_sts_t        sts,
	output smm_cmd_t        cmd
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	smm_state_t       state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             last_k, last_i, last_j, last_ij;

	assign last_k  = (DIM_W'(k_q) + DIM_W'(1)) == dims.a_cols;
	assign last_i  = (DIM_W'(i_q) + DIM_W'(1)) == dims.a_rows;
	assign last_j  = (DIM_W'(j_q) + DIM_W'(1)) == dims.b_cols;
	assign last_ij = last_i && last_j;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && op == OP_COMPUTE) begin
					state_d = (dims.a_cols != dims.b_rows) ? ST_ERR : ST_MAC;
				end
			end
			ST_MAC: begin
				if (last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.slot_free) begin
					state_d = last_ij ? ST_IDLE : ST_MAC;
				end
			end
			ST_ERR: begin
				if (sts.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.row       = COORD_W'(i_q);
		cmd.col       = COORD_W'(j_q);
		cmd.k         = COORD_W'(k_q);
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.wr_a = s_tvalid && op == OP_LOAD_A;
				cmd.wr_b = s_tvalid && op == OP_LOAD_B;
			end
			ST_MAC: begin
				cmd.rd_en   = 1'b1;
				cmd.clr_acc = k_q == '0;
			end
			ST_EMIT: begin
				cmd.emit_elem = sts.slot_free;
				cmd.last      = last_ij;
			end
			ST_ERR: begin
				cmd.emit_err = sts.slot_free;
				cmd.last     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				ST_MAC: begin
					k_q <= last_k ? '0 : k_q + IDX_W'(1);
				end
				ST_EMIT: begin
					if (sts.slot_free && !last_ij) begin
						if (last_j) begin
							j_q <= '0;
							i_q <= i_q + IDX_W'(1);
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

`include "small_matrix_multiply_core_assert.svh"

	`SMM_ASSERT_NEXT(a_last_to_idle, (cmd.emit_elem || cmd.emit_err) && cmd.last, state_q == ST_IDLE, "run did not end after last word")
	`SMM_ASSERT_SAME(a_emit_drained, cmd.emit_elem, !sts.pipe_busy, "element emitted before sum complete")
	`SMM_ASSERT_SAME(a_load_accepted, cmd.wr_a || cmd.wr_b, s_tvalid && s_tready, "store write without accepted word")

endmodule

// ----- src/smm_dp.sv -----
// Datapath: element stores, multiply-accumulate pipe, rounding and output register.
module smm_dp
	import smm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smm_cmd_t             cmd,
	input  logic [COORD_W-1:0]   elem_row,
	input  logic [COORD_W-1:0]   elem_col,
	input  logic [ELEM_BITS-1:0] elem_value,
	input  logic                 m_tready,
	output smm_sts_t             sts,
	output logic                 out_valid,
	output logic                 out_status,
	output logic [COORD_W-1:0]   out_row,
	output logic [COORD_W-1:0]   out_col,
	output logic [ELEM_BITS-1:0] out_value,
	output logic                 out_last
);

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int ACC_W  = PROD_W + IDX_W + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (ELEM_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	logic [ELEM_BITS-1:0] mem_a_q [DEPTH];
	logic [ELEM_BITS-1:0] mem_b_q [DEPTH];

	logic                      in_range;
	logic [ADDR_W-1:0]         wr_addr, rd_addr_a, rd_addr_b;
	logic signed [ELEM_BITS-1:0] a_s1, b_s1;
	logic                      v_s1, v_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   shifted;
	logic [ELEM_BITS-1:0]      sat_value;
	logic                      out_valid_q, out_status_q, out_last_q;
	logic [COORD_W-1:0]        out_row_q, out_col_q;
	logic [ELEM_BITS-1:0]      out_value_q;
	logic                      emit;

	assign in_range  = (DIM_W'(elem_row) < DIM_W'(MAX_DIM)) && (DIM_W'(elem_col) < DIM_W'(MAX_DIM));
	assign wr_addr   = {elem_row[IDX_W-1:0], elem_col[IDX_W-1:0]};
	assign rd_addr_a = {cmd.row[IDX_W-1:0], cmd.k[IDX_W-1:0]};
	assign rd_addr_b = {cmd.k[IDX_W-1:0], cmd.col[IDX_W-1:0]};

	// stores: one write port for loads, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (cmd.wr_a && in_range) begin
			mem_a_q[wr_addr] <= elem_value;
		end
		if (cmd.wr_b && in_range) begin
			mem_b_q[wr_addr] <= elem_value;
		end
		a_s1    <= mem_a_q[rd_addr_a];
		b_s1    <= mem_b_q[rd_addr_b];
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	// full-width sum; no overflow possible at this width
	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// floor to Q8.8 then clamp
	assign shifted = acc_q >>> FRAC_BITS;

	always_comb begin
		if (shifted > SAT_HI) begin
			sat_value = SAT_HI[ELEM_BITS-1:0];
		end else if (shifted < SAT_LO) begin
			sat_value = SAT_LO[ELEM_BITS-1:0];
		end else begin
			sat_value = shifted[ELEM_BITS-1:0];
		end
	end

	assign emit = cmd.emit_elem || cmd.emit_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_status_q <= STATUS_MISMATCH;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.emit_elem) begin
			out_status_q <= STATUS_OK;
			out_row_q    <= cmd.row;
			out_col_q    <= cmd.col;
			out_value_q  <= sat_value;
			out_last_q   <= cmd.last;
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.slot_free = !out_valid_q || m_tready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;

`include "small_matrix_multiply_core_assert.svh"

	`SMM_ASSERT_SAME(a_emit_slot, emit, !out_valid_q || m_tready, "output word overwritten")
	`SMM_ASSERT_SAME(a_clr_idle_pipe, cmd.clr_acc, !v_s2, "sum cleared with product in flight")
	`SMM_ASSERT_SAME(a_load_quiet, cmd.wr_a || cmd.wr_b, !(v_s1 || v_s2), "store write during walk")

endmodule

// ----- src/small_matrix_multiply_core.sv -----
// Top level of the small signed Q8.8 matrix multiplier.
//
// Input stream (s_t*): each word is a load of one element of A or B, or a compute
//   command; s_tuser carries the operation. Loads and op 3 give no output word.
//   Loads with a row or column outside the store are dropped.
// Output stream (m_t*): a compute emits A x B in row-major order, m_tlast on the
//   final element; when a_cols differs from b_rows it emits one word with
//   m_tuser set, all data zero and m_tlast high.
// Timing: each product element is built from a_cols reads of the two stores, a multiply
//   stage, the accumulate, then the output load. A mismatch word is loaded into the
//   output register once it is free, after the command is taken. The input is held
//   off for the whole compute run; the next word is taken once the last result sits
//   in the output register, even if the receiver has not yet taken it.
// Stall: a low m_tready freezes the walk before the next element is written into
//   the single output register; nothing is lost or repeated.
// Config: APB registers a_rows, a_cols, b_rows, b_cols at 0x0, 0x4, 0x8, 0xC
//   (4 bits, reset 8; 0 is used as 1, above MAX_DIM as MAX_DIM). Write only while idle.
// Reset: arst_n clears control state; store contents are undefined until loaded.
module small_matrix_multiply_core
	import smm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // elem_row[2:0], elem_col[5:3], elem_value[21:6], zero
	input  logic [1:0]  s_tuser,   // op[1:0]
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[21:6], zero
	output logic [0:0]  m_tuser,   // status[0]
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic             cfg_wr;
	logic [DIM_W-1:0] rd_val;
	smm_dims_t        dims;
	smm_cmd_t         cmd;
	smm_sts_t         sts;
	logic             out_status, out_last;
	logic [COORD_W-1:0]   out_row, out_col;
	logic [ELEM_BITS-1:0] out_value;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

	// ---- register port: zero wait states, decode on word address ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(8);
			a_cols_q <= DIM_W'(8);
			b_rows_q <= DIM_W'(8);
			b_cols_q <= DIM_W'(8);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_A_ROWS: a_rows_q <= pwdata[DIM_W-1:0];
				REG_A_COLS: a_cols_q <= pwdata[DIM_W-1:0];
				REG_B_ROWS: b_rows_q <= pwdata[DIM_W-1:0];
				REG_B_COLS: b_cols_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_A_ROWS: rd_val = a_rows_q;
			REG_A_COLS: rd_val = a_cols_q;
			REG_B_ROWS: rd_val = b_rows_q;
			REG_B_COLS: rd_val = b_cols_q;
			default:    rd_val = '0;
		endcase
	end

	assign prdata = {{(32 - DIM_W){1'b0}}, rd_val};

	// sizes the sequencer works with
	assign dims.a_rows = clamp_dim(a_rows_q);
	assign dims.a_cols = clamp_dim(a_cols_q);
	assign dims.b_rows = clamp_dim(b_rows_q);
	assign dims.b_cols = clamp_dim(b_cols_q);

	smm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.dims     (dims),
		.sts      (sts),
		.cmd      (cmd)
	);

	smm_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.elem_row   (s_tdata[2:0]),
		.elem_col   (s_tdata[5:3]),
		.elem_value (s_tdata[21:6]),
		.m_tready   (m_tready),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.out_last   (out_last)
	);

	assign m_tdata = {2'b00, out_value, out_col, out_row};
	assign m_tuser = out_status;
	assign m_tlast = out_last;

endmodule
